// ===== sv/sct_pkg.sv =====
`default_nettype none

package sct_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int unsigned COUNTER_BITS = 2;
  localparam int unsigned SLOT_W       = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned INDEX_W  = 32;
  localparam int unsigned IN_DATA_W  = 40;  // index + taken, padded to whole bytes
  localparam int unsigned OUT_DATA_W = 8;   // prediction, padded to a byte

  // Counter thresholds
  localparam int unsigned SAT_VAL = (COUNTER_BITS > 1) ? (1 << (COUNTER_BITS - 1)) : 1;
  localparam int unsigned MAX_VAL = (1 << COUNTER_BITS) - 1;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [SLOT_W-1:0]       slot_t;

  localparam cnt_t CNT_SAT     = cnt_t'(SAT_VAL);
  localparam cnt_t CNT_NOT_SAT = cnt_t'(SAT_VAL - 1);
  localparam cnt_t CNT_MAX     = cnt_t'(MAX_VAL);
  localparam cnt_t CNT_ZERO    = cnt_t'(0);
  localparam cnt_t CNT_ONE     = cnt_t'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PREDICT = 2'd0,
    MODE_TRAIN   = 2'd1,
    MODE_FORCE   = 2'd2
  } mode_e;

  // Value an entry holds after reset: 1 on even slots, SAT-1 on odd ones
  function automatic cnt_t cnt_reset_value(input logic slot_lsb);
    cnt_t v;
    v = slot_lsb ? CNT_NOT_SAT : CNT_ONE;
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sct_ram.sv =====
`default_nettype none

module sct_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, returns the old word on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/saturating_counter_table.sv =====
// Bimodal table of saturating counters. Each input word carries a mode in tuser
// (predict, train, force) and an id plus outcome in tdata; the low bits of the
// id pick one counter. Predict and train return one word holding the prediction
// taken before any update; force and the unused mode return nothing. One word
// is taken per clock unless a result word waits on a low m_axis_tready: the
// table read is registered, the update and the result are formed in the next
// cycle, and a one-deep bypass of the last write covers back-to-back hits on
// the same slot. A result word passes the lookup stage and then the result
// register, and is held while m_axis_tready is low. After reset the block walks
// the table once, one slot per cycle, to load the initial counts;
// s_axis_tready stays low until that walk is done.
`default_nettype none

module saturating_counter_table (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] index, [32] taken, [39:33] zero
  input  wire logic [sct_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] mode
  input  wire logic [sct_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] prediction, [7:1] zero
  output logic      [sct_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import sct_pkg::*;

  // Reset sweep
  logic  clr_busy_q, clr_busy_d;
  slot_t clr_addr_q, clr_addr_d;

  // Lookup stage
  logic  s1_valid_q, s1_valid_d;
  mode_e s1_mode_q;
  slot_t s1_slot_q;
  logic  s1_taken_q;

  // Last write bypass
  logic  fwd_valid_q, fwd_valid_d;
  slot_t fwd_slot_q;
  cnt_t  fwd_cnt_q;

  // Result register
  logic  out_valid_q, out_valid_d;
  logic  out_pred_q;

  logic  in_accept;
  logic  s1_has_result, s1_writes, s1_adv, s1_wr;
  cnt_t  ram_rdata, cur_cnt, new_cnt;
  logic  cur_pred;
  logic  ram_we;
  slot_t ram_waddr;
  cnt_t  ram_wdata;

  // Table storage
  sct_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (s_axis_tdata[SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Pick the current count, preferring the last write when it hit the same slot
  always_comb begin
    cur_cnt = (fwd_valid_q && (fwd_slot_q == s1_slot_q)) ? fwd_cnt_q : ram_rdata;
    cur_pred = (cur_cnt >= CNT_SAT);
    s1_has_result = 1'b0;
    s1_writes     = 1'b0;
    new_cnt       = cur_cnt;
    case (s1_mode_q)
      MODE_PREDICT: begin
        s1_has_result = 1'b1;
      end
      MODE_TRAIN: begin
        s1_has_result = 1'b1;
        s1_writes     = 1'b1;
        if (s1_taken_q) begin
          new_cnt = (cur_cnt != CNT_MAX) ? cur_cnt + CNT_ONE : cur_cnt;
        end else begin
          new_cnt = (cur_cnt != CNT_ZERO) ? cur_cnt - CNT_ONE : cur_cnt;
        end
      end
      MODE_FORCE: begin
        s1_writes = 1'b1;
        new_cnt   = s1_taken_q ? CNT_SAT : CNT_NOT_SAT;
      end
      default: begin
        s1_has_result = 1'b0;
      end
    endcase
  end

  // Handshake and advance
  always_comb begin
    s1_adv        = s1_valid_q && (!s1_has_result || !out_valid_q || m_axis_tready);
    s1_wr         = s1_adv && s1_writes;
    s_axis_tready = !clr_busy_q && (!s1_valid_q || s1_adv);
    in_accept     = s_axis_tvalid && s_axis_tready;
  end

  // Table write port: sweep first, then updates
  always_comb begin
    ram_we    = clr_busy_q || s1_wr;
    ram_waddr = clr_busy_q ? clr_addr_q : s1_slot_q;
    ram_wdata = clr_busy_q ? cnt_reset_value(clr_addr_q[0]) : new_cnt;
  end

  // Next state of control registers
  always_comb begin
    clr_busy_d  = clr_busy_q;
    clr_addr_d  = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + slot_t'(1);
      if (clr_addr_q == slot_t'(TABLE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    s1_valid_d  = in_accept || (s1_valid_q && !s1_adv);
    fwd_valid_d = fwd_valid_q || s1_wr;
    if (s1_adv && s1_has_result) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      fwd_valid_q <= fwd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q  <= mode_e'(s_axis_tuser);
      s1_slot_q  <= s_axis_tdata[SLOT_W-1:0];
      s1_taken_q <= s_axis_tdata[INDEX_W];
    end
    if (s1_wr) begin
      fwd_slot_q <= s1_slot_q;
      fwd_cnt_q  <= new_cnt;
    end
    if (s1_adv && s1_has_result) begin
      out_pred_q <= cur_pred;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, out_pred_q};

endmodule

`default_nettype wire

// ===== sv/sct_checker.sv =====
`default_nettype none

module sct_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [sct_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input wire logic [sct_pkg::MODE_W-1:0]      s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [sct_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import sct_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  // A fresh result word goes out only after its input word is taken
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result word without a preceding input word");

  // Refuse input right after reset is released, while the table is being loaded
  a_sweep_blocks: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !s_axis_tready)
    else $error("input taken during the reset sweep");

  // Keep padding bits of the result clear
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:1] == '0))
    else $error("result padding not zero");

endmodule

bind saturating_counter_table sct_checker u_sct_checker (.*);

`default_nettype wire
